[src/dtwea_pkg.sv]
// ----------------------------------------------------------------------------
// dtwea_pkg
// types, codes and arithmetic helpers for the warping cost unit
// ----------------------------------------------------------------------------
`default_nettype none

package dtwea_pkg;

  localparam int COST_W = 48;
  localparam int DIST_W = 34;
  localparam int PT_W   = 32;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_REF = 2'd0,
    KIND_QRY = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_ABAND = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] point_value;
    logic [15:0] point_weight;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [1:0]        status;
    logic              truncated;
  } out_item_t;

  typedef struct packed {
    logic            v;
    logic            first;
    logic            last;
    logic [PT_W-1:0] pt;
  } pt_link_t;

  typedef struct packed {
    logic              v;
    logic              first;
    logic              last;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] rmin;
  } cost_link_t;

  function automatic logic [DIST_W-1:0] point_dist(logic [PT_W-1:0] p, logic [PT_W-1:0] q);
    logic signed [16:0] dv;
    logic signed [16:0] dw;
    logic signed [33:0] sv;
    logic signed [33:0] sw;
    dv = $signed({p[31], p[31:16]}) - $signed({q[31], q[31:16]});
    dw = $signed({p[15], p[15:0]}) - $signed({q[15], q[15:0]});
    sv = dv * dv;
    sw = dw * dw;
    return $unsigned(sv) + $unsigned(sw);
  endfunction

  function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] min2(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[src/dtwea_ram.sv]
// ----------------------------------------------------------------------------
// dtwea_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dtwea_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/dtwea_cell.sv]
// ----------------------------------------------------------------------------
// dtwea_cell
// one query column of the warping matrix: holds the query point and the
// column's previous-row cost, passes reference points and costs rightwards
// ----------------------------------------------------------------------------
`default_nettype none

module dtwea_cell #(
  parameter int MAX_POINTS = 256,
  parameter int J          = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_we,
  input  wire logic [$clog2(MAX_POINTS)-1:0]     q_idx,
  input  wire logic [dtwea_pkg::PT_W-1:0]        q_data,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]   qcnt,
  input  wire logic                              m_one,
  input  wire dtwea_pkg::pt_link_t               pin,
  input  wire dtwea_pkg::cost_link_t             cin,
  output dtwea_pkg::pt_link_t                    pout_r,
  output dtwea_pkg::cost_link_t                  cout_r
);

  import dtwea_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS+1);

  logic [PT_W-1:0]   q_r;
  logic [DIST_W-1:0] dist_r;
  logic              fl_v_r, fl_first_r, fl_last_r;
  logic [COST_W-1:0] up_r, diag_r;
  logic              active;
  logic [COST_W-1:0] d_ext, best, sum, rmin;
  cost_link_t        cout_nxt;

  assign active = (CW'(J) < qcnt);
  assign d_ext  = {{(COST_W-DIST_W){1'b0}}, dist_r};

  always_comb begin
    best = min2(min2(cin.cost, up_r), diag_r);
    if (J == 0) begin
      sum  = fl_first_r ? d_ext : sat_add(d_ext, up_r);
      rmin = m_one ? sum : COST_MAX;
    end else begin
      sum  = fl_first_r ? sat_add(d_ext, cin.cost) : sat_add(d_ext, best);
      rmin = min2(cin.rmin, sum);
    end
    if (active) begin
      cout_nxt = '{v: fl_v_r, first: fl_first_r, last: fl_last_r, cost: sum, rmin: rmin};
    end else begin
      cout_nxt = cin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pout_r.v <= 1'b0;
      cout_r.v <= 1'b0;
      fl_v_r   <= 1'b0;
    end else begin
      pout_r.v <= pin.v;
      cout_r.v <= cout_nxt.v;
      fl_v_r   <= pin.v;
    end
    pout_r.first <= pin.first;
    pout_r.last  <= pin.last;
    pout_r.pt    <= pin.pt;
    fl_first_r   <= pin.first;
    fl_last_r    <= pin.last;
    dist_r       <= point_dist(pin.pt, q_r);
    cout_r.first <= cout_nxt.first;
    cout_r.last  <= cout_nxt.last;
    cout_r.cost  <= cout_nxt.cost;
    cout_r.rmin  <= cout_nxt.rmin;
    if (q_we && q_idx == AW'(J)) begin
      q_r <= q_data;
    end
    if (fl_v_r && active) begin
      up_r   <= sum;
      diag_r <= cin.cost;
    end
  end

endmodule

`default_nettype wire

[src/dtw_distance_early_abandon_unit.sv]
// ----------------------------------------------------------------------------
// dtw_distance_early_abandon_unit
// warping cost of two point series on a systolic row of query cells
// ----------------------------------------------------------------------------
// load items: one per cycle while idle, no result
// compute item: result after the last of the n reference points has
//   entered the cell chain, one reference row per cycle, and the wavefront
//   has crossed all MAX_POINTS cells; empty series answer without a compute
// input is held off while a compute runs
// reset (rst_n, synchronous): counts and flags cleared, threshold all ones
// ----------------------------------------------------------------------------
`default_nettype none

module dtw_distance_early_abandon_unit #(
  parameter int MAX_POINTS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire dtwea_pkg::in_item_t           in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dtwea_pkg::out_item_t               out_item,
  input  wire logic                          cfg_we,
  input  wire logic [dtwea_pkg::COST_W-1:0]  cfg_wdata
);

  import dtwea_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS+1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     n_r, m_r, k_r;
  logic              ovf_r;
  logic [COST_W-1:0] thr_r;
  logic              iss_v_r, iss_first_r, iss_last_r;
  logic              ab_r;
  logic [COST_W-1:0] ab_cost_r, res_cost_r;
  logic [1:0]        res_status_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic              acc, issue, ref_we, q_we, abnow;
  logic [PT_W-1:0]   pt_in, ram_q;

  pt_link_t   pl [MAX_POINTS+1];
  cost_link_t cl [MAX_POINTS+1];

  assign acc    = in_valid && in_ready;
  assign pt_in  = {in_item.point_value, in_item.point_weight};
  assign ref_we = acc && in_item.kind == KIND_REF && n_r < CW'(MAX_POINTS);
  assign q_we   = acc && in_item.kind == KIND_QRY && m_r < CW'(MAX_POINTS);
  assign abnow  = !cl[MAX_POINTS].first && cl[MAX_POINTS].rmin >= thr_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  dtwea_ram #(.W(PT_W), .DEPTH(MAX_POINTS)) u_ref_ram (
    .clk    (clk),
    .we     (ref_we),
    .waddr  (n_r[AW-1:0]),
    .wdata  (pt_in),
    .raddr  (k_r[AW-1:0]),
    .rdata_r(ram_q)
  );

  assign pl[0] = '{v: iss_v_r, first: iss_first_r, last: iss_last_r, pt: ram_q};
  assign cl[0] = '0;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    dtwea_cell #(.MAX_POINTS(MAX_POINTS), .J(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .q_we  (q_we),
      .q_idx (m_r[AW-1:0]),
      .q_data(pt_in),
      .qcnt  (m_r),
      .m_one (m_r == CW'(1)),
      .pin   (pl[g]),
      .cin   (cl[g]),
      .pout_r(pl[g+1]),
      .cout_r(cl[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_item.kind == KIND_RUN) begin
          state_nxt = (n_r == '0 || m_r == '0) ? ST_RESULT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_r == n_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cl[MAX_POINTS].v && cl[MAX_POINTS].last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_ISSUE: issue    = 1'b1;
      default: begin
        in_ready = 1'b0;
        issue    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      m_r         <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= COST_MAX;
      iss_v_r     <= 1'b0;
      ab_r        <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      iss_v_r <= issue;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      k_r <= issue ? k_r + CW'(1) : '0;
      if (ref_we) begin
        n_r <= n_r + CW'(1);
      end
      if (q_we) begin
        m_r <= m_r + CW'(1);
      end
      if (acc && (in_item.kind == KIND_REF || in_item.kind == KIND_QRY) && !ref_we && !q_we) begin
        ovf_r <= 1'b1;
      end
      if (state_r == ST_IDLE) begin
        ab_r <= 1'b0;
      end else if (state_r == ST_DRAIN && cl[MAX_POINTS].v && abnow) begin
        ab_r <= 1'b1;
      end
      if (state_r == ST_RESULT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        n_r         <= '0;
        m_r         <= '0;
        ovf_r       <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    iss_first_r <= (k_r == '0);
    iss_last_r  <= (k_r == n_r - CW'(1));
    if (state_r == ST_DRAIN && cl[MAX_POINTS].v && abnow && !ab_r) begin
      ab_cost_r <= cl[MAX_POINTS].rmin;
    end
    if (acc && in_item.kind == KIND_RUN) begin
      res_cost_r   <= COST_MAX;
      res_status_r <= STAT_EMPTY;
    end
    if (state_r == ST_DRAIN && cl[MAX_POINTS].v && cl[MAX_POINTS].last) begin
      if (ab_r) begin
        res_cost_r   <= ab_cost_r;
        res_status_r <= STAT_ABAND;
      end else if (abnow) begin
        res_cost_r   <= cl[MAX_POINTS].rmin;
        res_status_r <= STAT_ABAND;
      end else begin
        res_cost_r   <= cl[MAX_POINTS].cost;
        res_status_r <= STAT_DONE;
      end
    end
    if (state_r == ST_RESULT && (!out_valid_r || out_ready)) begin
      out_item_r <= '{cost: res_cost_r, status: res_status_r, truncated: ovf_r};
    end
  end

endmodule

`default_nettype wire
